FILE: hdl/grpe_pkg.sv
// shared types, codes and font geometry for the glyph row pixel expander
package grpe_pkg;

	// input item kinds
	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_RENDER = 1'b1;

	// font codes, used both for font_select and for table_pick
	localparam logic [1:0] FONT_SMALL  = 2'd0;
	localparam logic [1:0] FONT_MIDDLE = 2'd1;
	localparam logic [1:0] FONT_BIG    = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_FONT_SELECT = 2'd0;
	localparam logic [1:0] CFG_FORE_COLOR  = 2'd1;
	localparam logic [1:0] CFG_BG_COLOR    = 2'd2;

	// reset values of the configuration registers
	localparam logic [15:0] FORE_COLOR_RESET = 16'hFFFF;
	localparam logic [15:0] BG_COLOR_RESET   = 16'h0000;

	// first printable character code
	localparam logic [7:0] FIRST_CODE = 8'd32;

	// glyph heights in rows
	localparam logic [4:0] SMALL_H  = 5'd16;
	localparam logic [4:0] MIDDLE_H = 5'd20;
	localparam logic [4:0] BIG_H    = 5'd26;

	// rightmost column of each font
	localparam logic [3:0] SMALL_LAST_COL  = 4'd7;
	localparam logic [3:0] MIDDLE_LAST_COL = 4'd11;
	localparam logic [3:0] BIG_LAST_COL    = 4'd15;

	// one glyph row handed to the pixel serializer
	typedef struct packed {
		logic        printable;
		logic [1:0]  font;
		logic [15:0] bits;
	} row_load_t;

	// glyph height of a font; unknown font reads as zero rows
	function automatic logic [4:0] font_height(input logic [1:0] font);
		logic [4:0] h;
		unique case (font)
			FONT_SMALL:  h = SMALL_H;
			FONT_MIDDLE: h = MIDDLE_H;
			FONT_BIG:    h = BIG_H;
			default:     h = 5'd0;
		endcase
		return h;
	endfunction

	// rightmost column of a font
	function automatic logic [3:0] font_last_col(input logic [1:0] font);
		logic [3:0] c;
		unique case (font)
			FONT_SMALL:  c = SMALL_LAST_COL;
			FONT_MIDDLE: c = MIDDLE_LAST_COL;
			default:     c = BIG_LAST_COL;
		endcase
		return c;
	endfunction

	// mirror a byte so the leftmost pixel lands in the top bit
	function automatic logic [7:0] reverse8(input logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = b[7 - i];
		end
		return r;
	endfunction

endpackage

FILE: hdl/grpe_ram.sv
// generic single write port memory with registered read
module grpe_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/grpe_serializer.sv
// row buffer and pixel serializer with output register
module grpe_serializer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_valid,
	input  grpe_pkg::row_load_t load,
	output logic                load_ready,
	input  logic [15:0]         fore_color,
	input  logic [15:0]         bg_color,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [15:0]         pixel_color,
	output logic [3:0]          pixel_column,
	output logic                last_in_row
);

	logic        busy_q;
	logic        print_q;
	logic [15:0] bits_q;
	logic [3:0]  col_q;
	logic [3:0]  last_col_q;

	logic out_free;
	logic emit;
	logic end_row;
	logic take;

	// handshake between row buffer and output register
	always_comb begin
		out_free   = !out_valid || !out_stall;
		emit       = busy_q && out_free;
		end_row    = emit && (col_q == last_col_q);
		load_ready = !busy_q || end_row;
		take       = load_valid && load_ready;
	end

	// row buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (take) begin
			busy_q <= 1'b1;
		end else if (end_row) begin
			busy_q <= 1'b0;
		end
	end

	// row buffer payload, bits kept leftmost pixel first
	always_ff @(posedge clk) begin
		if (take) begin
			print_q    <= load.printable;
			col_q      <= 4'd0;
			last_col_q <= grpe_pkg::font_last_col(load.font);
			if (load.font == grpe_pkg::FONT_SMALL) begin
				bits_q <= {grpe_pkg::reverse8(load.bits[7:0]), 8'h00};
			end else begin
				bits_q <= load.bits;
			end
		end else if (emit) begin
			bits_q <= {bits_q[14:0], 1'b0};
			col_q  <= col_q + 4'd1;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= emit;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_color  <= (print_q && bits_q[15]) ? fore_color : bg_color;
			pixel_column <= col_q;
			last_in_row  <= (col_q == last_col_q);
		end
	end

endmodule

FILE: hdl/glyph_row_pixel_expander_unit.sv
// top level of the glyph row pixel expander: pipeline, font stores and config
// A render item turns one glyph row into 8, 12 or 16 pixel transfers, one per
// cycle while out_stall is low, for the small, middle and big font. The pixel
// serializer takes the next row as it emits the last pixel of the current one.
// Font writes and rows that emit nothing stop at the input register. A row's
// first pixel passes the input, store address and store read registers, then the
// serializer row buffer and output register. The font stores come up with no
// clearing pass: a glyph must be written before it is rendered.
module glyph_row_pixel_expander_unit #(
	parameter int GLYPH_COUNT = 95
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [7:0]  char_code,
	input  logic [4:0]  glyph_row,
	input  logic [1:0]  table_pick,
	input  logic [11:0] table_address,
	input  logic [15:0] table_word,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] pixel_color,
	output logic [3:0]  pixel_column,
	output logic        last_in_row
);

	localparam int SMALL_DEPTH  = GLYPH_COUNT * 16;
	localparam int MIDDLE_DEPTH = GLYPH_COUNT * 20;
	localparam int BIG_DEPTH    = GLYPH_COUNT * 26;
	localparam int SMALL_AW     = $clog2(SMALL_DEPTH);
	localparam int MIDDLE_AW    = $clog2(MIDDLE_DEPTH);
	localparam int BIG_AW       = $clog2(BIG_DEPTH);
	localparam int IDX_W        = BIG_AW;
	localparam int AEXT_W       = (IDX_W > 12) ? IDX_W : 12;

	// configuration registers
	logic [1:0]  font_select_q;
	logic [15:0] fore_color_q;
	logic [15:0] bg_color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_select_q <= grpe_pkg::FONT_SMALL;
			fore_color_q  <= grpe_pkg::FORE_COLOR_RESET;
			bg_color_q    <= grpe_pkg::BG_COLOR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				grpe_pkg::CFG_FONT_SELECT: font_select_q <= cfg_data[1:0];
				grpe_pkg::CFG_FORE_COLOR:  fore_color_q  <= cfg_data;
				grpe_pkg::CFG_BG_COLOR:    bg_color_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline stage registers
	logic              v_s1;
	logic              kind_s1;
	logic [7:0]        code_s1;
	logic [4:0]        row_s1;
	logic [1:0]        pick_s1;
	logic [11:0]       addr_s1;
	logic [15:0]       word_s1;

	logic              v_s2;
	logic              print_s2;
	logic [1:0]        font_s2;
	logic [IDX_W-1:0]  idx_s2;

	logic              v_s3;
	logic              print_s3;
	logic [1:0]        font_s3;

	// stage flow control, back from the serializer
	logic                load_ready;
	logic                s1_free;
	logic                s2_free;
	logic                s3_free;
	logic                adv2;
	logic                load_s3;
	grpe_pkg::row_load_t row_load;

	always_comb begin
		load_s3  = v_s3 && load_ready;
		s3_free  = !v_s3 || load_ready;
		adv2     = v_s2 && s3_free;
		s2_free  = !v_s2 || s3_free;
		s1_free  = !v_s1 || s2_free;
		in_stall = !s1_free;
	end

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && in_valid) begin
			kind_s1 <= kind;
			code_s1 <= char_code;
			row_s1  <= glyph_row;
			pick_s1 <= table_pick;
			addr_s1 <= table_address;
			word_s1 <= table_word;
		end
	end

	// stage 1 decode: store writes, row range, glyph index
	logic              go_s1;
	logic              render_ok;
	logic              printable;
	logic [4:0]        height;
	logic [7:0]        glyph;
	logic [12:0]       prod;
	logic [13:0]       idx_full;
	logic [AEXT_W-1:0] waddr_ext;
	logic              small_we;
	logic              middle_we;
	logic              big_we;

	always_comb begin
		go_s1     = v_s1 && s2_free;
		height    = grpe_pkg::font_height(font_select_q);
		render_ok = (kind_s1 == grpe_pkg::KIND_RENDER) && (height != 5'd0)
			&& (row_s1 < height);
		glyph     = code_s1 - grpe_pkg::FIRST_CODE;
		printable = (code_s1 >= grpe_pkg::FIRST_CODE) && (32'(glyph) < GLYPH_COUNT);
		prod      = 13'(glyph) * 13'(height);
		idx_full  = 14'(prod) + 14'(row_s1);
		waddr_ext = AEXT_W'(addr_s1);
		small_we  = go_s1 && (kind_s1 == grpe_pkg::KIND_WRITE)
			&& (pick_s1 == grpe_pkg::FONT_SMALL) && (32'(addr_s1) < SMALL_DEPTH);
		middle_we = go_s1 && (kind_s1 == grpe_pkg::KIND_WRITE)
			&& (pick_s1 == grpe_pkg::FONT_MIDDLE) && (32'(addr_s1) < MIDDLE_DEPTH);
		big_we    = go_s1 && (kind_s1 == grpe_pkg::KIND_WRITE)
			&& (pick_s1 == grpe_pkg::FONT_BIG) && (32'(addr_s1) < BIG_DEPTH);
	end

	// stage 2: store address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= v_s1 && render_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			print_s2 <= printable;
			font_s2  <= font_select_q;
			idx_s2   <= printable ? IDX_W'(idx_full) : '0;
		end
	end

	// font stores
	logic [7:0]  small_q;
	logic [15:0] middle_q;
	logic [15:0] big_q;

	grpe_ram #(.DEPTH(SMALL_DEPTH), .WIDTH(8)) u_small_store (
		.clk   (clk),
		.we    (small_we),
		.waddr (waddr_ext[SMALL_AW-1:0]),
		.wdata (word_s1[7:0]),
		.re    (adv2),
		.raddr (idx_s2[SMALL_AW-1:0]),
		.rdata (small_q)
	);

	grpe_ram #(.DEPTH(MIDDLE_DEPTH), .WIDTH(16)) u_middle_store (
		.clk   (clk),
		.we    (middle_we),
		.waddr (waddr_ext[MIDDLE_AW-1:0]),
		.wdata (word_s1),
		.re    (adv2),
		.raddr (idx_s2[MIDDLE_AW-1:0]),
		.rdata (middle_q)
	);

	grpe_ram #(.DEPTH(BIG_DEPTH), .WIDTH(16)) u_big_store (
		.clk   (clk),
		.we    (big_we),
		.waddr (waddr_ext[BIG_AW-1:0]),
		.wdata (word_s1),
		.re    (adv2),
		.raddr (idx_s2[BIG_AW-1:0]),
		.rdata (big_q)
	);

	// stage 3: store data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (s3_free) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			print_s3 <= print_s2;
			font_s3  <= font_s2;
		end
	end

	// pick the active store's word for the serializer
	always_comb begin
		row_load.printable = print_s3;
		row_load.font      = font_s3;
		unique case (font_s3)
			grpe_pkg::FONT_SMALL:  row_load.bits = {8'h00, small_q};
			grpe_pkg::FONT_MIDDLE: row_load.bits = middle_q;
			default:               row_load.bits = big_q;
		endcase
	end

	grpe_serializer u_serializer (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_valid   (load_s3),
		.load         (row_load),
		.load_ready   (load_ready),
		.fore_color   (fore_color_q),
		.bg_color     (bg_color_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_color  (pixel_color),
		.pixel_column (pixel_column),
		.last_in_row  (last_in_row)
	);

	// the input only stalls behind a held item
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1)
		else $error("input stalled with empty first stage");

	// stores are read only for a live render item
	a_read_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		adv2 |-> v_s2 && (v_s3 == 1'b0 || load_ready))
		else $error("store read without an item to carry");

	// a row ends only on a font's rightmost column
	a_last_column: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_in_row |->
			pixel_column == grpe_pkg::SMALL_LAST_COL
			|| pixel_column == grpe_pkg::MIDDLE_LAST_COL
			|| pixel_column == grpe_pkg::BIG_LAST_COL)
		else $error("row ended on a column no font ends on");

	// pixels of one row follow without gaps
	a_row_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_in_row |=>
			out_valid && pixel_column == 4'($past(pixel_column) + 4'd1))
		else $error("row broke off before its last pixel");

endmodule

FILE: sim/tb_glyph_row_pixel_expander_unit.sv
// testbench for the glyph row pixel expander: font loads, row renders, pixel checks
module tb_glyph_row_pixel_expander_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GLYPH_COUNT = 95;
	localparam int MAX_DEPTH = GLYPH_COUNT * int'(grpe_pkg::BIG_H);
	localparam int SETTLE_CYCLES = 12;
	localparam int CYCLE_LIMIT = 400000;
	// font code with no glyph geometry, also a store number with no store
	localparam logic [1:0] FONT_NONE = 2'd3;

	typedef struct packed {
		logic        kind;
		logic [7:0]  code;
		logic [4:0]  row;
		logic [1:0]  pick;
		logic [11:0] addr;
		logic [15:0] word;
	} glyph_item_t;

	typedef struct packed {
		logic [15:0] color;
		logic [3:0]  column;
		logic        last;
	} pixel_t;

	// shadow copy of fonts and registers, plus the queue of pixels still to come
	class pixel_scoreboard;
		logic [15:0] font_rows [3][MAX_DEPTH];
		bit          font_filled [3][MAX_DEPTH];
		int          small_filled[$];
		int          middle_filled[$];
		int          big_filled[$];
		logic [1:0]  font_sel;
		logic [15:0] fore;
		logic [15:0] back;
		pixel_t      pixel_q[$];
		int unsigned errors;
		int unsigned pixels_seen;

		function new();
			font_sel = grpe_pkg::FONT_SMALL;
			fore = grpe_pkg::FORE_COLOR_RESET;
			back = grpe_pkg::BG_COLOR_RESET;
			errors = 0;
			pixels_seen = 0;
		endfunction

		function int unsigned glyph_height(logic [1:0] f);
			case (f)
				grpe_pkg::FONT_SMALL:  return int'(grpe_pkg::SMALL_H);
				grpe_pkg::FONT_MIDDLE: return int'(grpe_pkg::MIDDLE_H);
				grpe_pkg::FONT_BIG:    return int'(grpe_pkg::BIG_H);
				default:               return 0;
			endcase
		endfunction

		function logic [3:0] glyph_last_col(logic [1:0] f);
			case (f)
				grpe_pkg::FONT_SMALL:  return grpe_pkg::SMALL_LAST_COL;
				grpe_pkg::FONT_MIDDLE: return grpe_pkg::MIDDLE_LAST_COL;
				default:               return grpe_pkg::BIG_LAST_COL;
			endcase
		endfunction

		function int unsigned store_depth(logic [1:0] f);
			return glyph_height(f) * GLYPH_COUNT;
		endfunction

		function bit is_printable(logic [7:0] code);
			return code >= grpe_pkg::FIRST_CODE
				&& int'(code) - int'(grpe_pkg::FIRST_CODE) < GLYPH_COUNT;
		endfunction

		function void note_config(logic [1:0] idx, logic [15:0] data);
			case (idx)
				grpe_pkg::CFG_FONT_SELECT: font_sel = data[1:0];
				grpe_pkg::CFG_FORE_COLOR:  fore = data;
				grpe_pkg::CFG_BG_COLOR:    back = data;
				default: ;
			endcase
		endfunction

		// true when a render of this code and row would fetch a never-written word
		function bit reads_unwritten(logic [7:0] code, logic [4:0] row);
			int unsigned h;
			h = glyph_height(font_sel);
			if (h == 0 || row >= h || !is_printable(code)) return 1'b0;
			return !font_filled[font_sel][(int'(code) - int'(grpe_pkg::FIRST_CODE)) * h + row];
		endfunction

		// a random written word index of the active font, -1 if there is none
		function int random_filled();
			case (font_sel)
				grpe_pkg::FONT_SMALL:
					if (small_filled.size() != 0)
						return small_filled[$urandom_range(0, small_filled.size() - 1)];
				grpe_pkg::FONT_MIDDLE:
					if (middle_filled.size() != 0)
						return middle_filled[$urandom_range(0, middle_filled.size() - 1)];
				grpe_pkg::FONT_BIG:
					if (big_filled.size() != 0)
						return big_filled[$urandom_range(0, big_filled.size() - 1)];
				default: ;
			endcase
			return -1;
		endfunction

		// apply a font write, or queue the pixels a row render produces
		function void note_item(glyph_item_t it);
			int unsigned h;
			int unsigned idx;
			logic [15:0] bits;
			logic [3:0]  last_col;
			pixel_t      px;
			if (it.kind == grpe_pkg::KIND_WRITE) begin
				if (it.addr < store_depth(it.pick)) begin
					font_rows[it.pick][it.addr] = (it.pick == grpe_pkg::FONT_SMALL) ?
						{8'h00, it.word[7:0]} : it.word;
					if (!font_filled[it.pick][it.addr]) begin
						font_filled[it.pick][it.addr] = 1'b1;
						case (it.pick)
							grpe_pkg::FONT_SMALL:  small_filled.push_back(int'(it.addr));
							grpe_pkg::FONT_MIDDLE: middle_filled.push_back(int'(it.addr));
							default:               big_filled.push_back(int'(it.addr));
						endcase
					end
				end
				return;
			end
			h = glyph_height(font_sel);
			if (h == 0 || it.row >= h) return;
			bits = 16'h0000;
			if (is_printable(it.code)) begin
				idx = (int'(it.code) - int'(grpe_pkg::FIRST_CODE)) * h + it.row;
				bits = font_rows[font_sel][idx];
			end
			last_col = glyph_last_col(font_sel);
			// small font is lsb-leftmost, the others msb-leftmost
			for (int col = 0; col <= int'(last_col); col++) begin
				if (font_sel == grpe_pkg::FONT_SMALL) px.color = bits[col] ? fore : back;
				else px.color = bits[15 - col] ? fore : back;
				px.column = 4'(col);
				px.last = (col == int'(last_col));
				pixel_q.push_back(px);
			end
		endfunction

		task report(string what, logic [15:0] got, logic [15:0] want);
			errors++;
			$display("error: pixel %0d %s got %h want %h", pixels_seen, what, got, want);
		endtask

		task check_pixel(logic [15:0] color, logic [3:0] column, logic last);
			pixel_t want;
			pixels_seen++;
			if (pixel_q.size() == 0) begin
				report("transfer with none expected", color, 16'h0000);
				return;
			end
			want = pixel_q.pop_front();
			if (color !== want.color) report("pixel_color", color, want.color);
			if (column !== want.column) report("pixel_column", 16'(column), 16'(want.column));
			if (last !== want.last) report("last_in_row", 16'(last), 16'(want.last));
		endtask

		function int unsigned pending();
			return pixel_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = grpe_pkg::CFG_FONT_SELECT;
	logic [15:0] cfg_data = 16'h0000;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        kind = grpe_pkg::KIND_WRITE;
	logic [7:0]  char_code = 8'h00;
	logic [4:0]  glyph_row = 5'd0;
	logic [1:0]  table_pick = grpe_pkg::FONT_SMALL;
	logic [11:0] table_address = 12'h000;
	logic [15:0] table_word = 16'h0000;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] pixel_color;
	logic [3:0]  pixel_column;
	logic        last_in_row;

	pixel_scoreboard sb = new();
	bit          quiet = 1'b0;
	int unsigned cycle_count = 0;
	int unsigned stall_left = 0;
	int unsigned n_renders = 0;
	int unsigned n_writes = 0;

	always #5 clk = ~clk;

	glyph_row_pixel_expander_unit #(
		.GLYPH_COUNT(GLYPH_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.char_code(char_code),
		.glyph_row(glyph_row),
		.table_pick(table_pick),
		.table_address(table_address),
		.table_word(table_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_color(pixel_color),
		.pixel_column(pixel_column),
		.last_in_row(last_in_row)
	);

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d pixels outstanding", cycle_count, sb.pending());
		$display("glyph_row_pixel_expander_unit: mismatch");
		$finish;
	end

	// output side: check each pixel transfer, then choose the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_pixel(pixel_color, pixel_column, last_in_row);
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (quiet || $urandom_range(0, 99) < 65) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= 1'b1;
			stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 40);
		end
	end

	// idle cycles before the next input transfer
	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (quiet) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic glyph_item_t write_item(logic [1:0] pick, logic [11:0] addr,
			logic [15:0] word);
		glyph_item_t it;
		it = glyph_item_t'({$urandom, $urandom});
		it.kind = grpe_pkg::KIND_WRITE;
		it.pick = pick;
		it.addr = addr;
		it.word = word;
		return it;
	endfunction

	function automatic glyph_item_t render_item(logic [7:0] code, logic [4:0] row);
		glyph_item_t it;
		it = glyph_item_t'({$urandom, $urandom});
		it.kind = grpe_pkg::KIND_RENDER;
		it.code = code;
		it.row = row;
		return it;
	endfunction

	// mostly writes into the active font and renders of rows already loaded
	function automatic glyph_item_t random_item();
		glyph_item_t it;
		int unsigned roll;
		int unsigned h;
		int          entry;
		it = render_item(8'($urandom), 5'($urandom));
		roll = $urandom_range(0, 99);
		if (roll < 35) begin
			it.kind = grpe_pkg::KIND_WRITE;
			if ($urandom_range(0, 3) != 0 && sb.font_sel != FONT_NONE) it.pick = sb.font_sel;
			if ($urandom_range(0, 6) != 0 && sb.store_depth(it.pick) != 0)
				it.addr = 12'($urandom_range(0, sb.store_depth(it.pick) - 1));
		end else begin
			entry = sb.random_filled();
			h = sb.glyph_height(sb.font_sel);
			if (roll < 85 && entry >= 0) begin
				it.code = 8'(int'(grpe_pkg::FIRST_CODE) + entry / h);
				it.row = 5'(entry % h);
			end else if (sb.reads_unwritten(it.code, it.row)) begin
				it.code = $urandom_range(0, 1) ?
					8'($urandom_range(0, int'(grpe_pkg::FIRST_CODE) - 1)) :
					8'($urandom_range(int'(grpe_pkg::FIRST_CODE) + GLYPH_COUNT, 255));
			end
		end
		return it;
	endfunction

	// one input transfer; returns at the edge where it is taken
	task automatic send_item(glyph_item_t it);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= it.kind;
		char_code <= it.code;
		glyph_row <= it.row;
		table_pick <= it.pick;
		table_address <= it.addr;
		table_word <= it.word;
		do @(posedge clk); while (in_stall);
		sb.note_item(it);
		if (it.kind == grpe_pkg::KIND_RENDER) n_renders++;
		else n_writes++;
	endtask

	task automatic run_random(int unsigned count);
		repeat (count) send_item(random_item());
	endtask

	// drain all pixels, then wait SETTLE_CYCLES to let the pipeline clear
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// writes all three registers back to back
	task automatic set_config(logic [1:0] font, logic [15:0] fore, logic [15:0] back);
		cfg_we <= 1'b1;
		cfg_index <= grpe_pkg::CFG_FONT_SELECT;
		cfg_data <= {14'd0, font};
		@(posedge clk);
		sb.note_config(grpe_pkg::CFG_FONT_SELECT, {14'd0, font});
		cfg_index <= grpe_pkg::CFG_FORE_COLOR;
		cfg_data <= fore;
		@(posedge clk);
		sb.note_config(grpe_pkg::CFG_FORE_COLOR, fore);
		cfg_index <= grpe_pkg::CFG_BG_COLOR;
		cfg_data <= back;
		@(posedge clk);
		sb.note_config(grpe_pkg::CFG_BG_COLOR, back);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// small font at reset colors: first and last glyph, codes around the printable range
		send_item(write_item(grpe_pkg::FONT_SMALL, 12'd0, 16'hFFA5));
		send_item(write_item(grpe_pkg::FONT_SMALL, 12'd1519, 16'h0081));
		send_item(render_item(8'd32, 5'd0));
		send_item(render_item(8'd126, 5'd15));
		send_item(render_item(8'd31, 5'd0));
		send_item(render_item(8'd127, 5'd7));
		send_item(render_item(8'd255, 5'd2));
		send_item(render_item(8'd32, 5'd16));
		send_item(render_item(8'd0, 5'd31));
		// writes that must be dropped: no such store, address past the store
		send_item(write_item(FONT_NONE, 12'd0, 16'hFFFF));
		send_item(write_item(grpe_pkg::FONT_SMALL, 12'd1520, 16'h00FF));
		send_item(write_item(grpe_pkg::FONT_MIDDLE, 12'hFFF, 16'hFFFF));

		wait_idle();
		set_config(grpe_pkg::FONT_MIDDLE, 16'h0000, 16'hFFFF);
		send_item(write_item(grpe_pkg::FONT_MIDDLE, 12'd0, 16'h8001));
		send_item(write_item(grpe_pkg::FONT_MIDDLE, 12'd1899, 16'hFFFF));
		send_item(render_item(8'd32, 5'd0));
		send_item(render_item(8'd126, 5'd19));
		send_item(render_item(8'd32, 5'd20));
		send_item(render_item(8'd200, 5'd19));

		wait_idle();
		set_config(grpe_pkg::FONT_BIG, 16'hF800, 16'h07E0);
		send_item(write_item(grpe_pkg::FONT_BIG, 12'd0, 16'h7FFE));
		send_item(write_item(grpe_pkg::FONT_BIG, 12'd2469, 16'h0000));
		send_item(render_item(8'd32, 5'd0));
		send_item(render_item(8'd126, 5'd25));
		send_item(render_item(8'd32, 5'd26));
		send_item(render_item(8'd31, 5'd25));

		// unknown font renders nothing
		wait_idle();
		set_config(FONT_NONE, 16'hFFFF, 16'h0000);
		send_item(render_item(8'd32, 5'd0));
		send_item(write_item(grpe_pkg::FONT_BIG, 12'd2470, 16'h1234));

		// random phases over each font and a few color settings
		wait_idle();
		set_config(grpe_pkg::FONT_SMALL, 16'($urandom), 16'($urandom));
		run_random(24);
		wait_idle();
		set_config(grpe_pkg::FONT_MIDDLE, 16'h0000, 16'hFFFF);
		run_random(24);
		wait_idle();
		quiet = 1'b1;
		set_config(grpe_pkg::FONT_BIG, 16'($urandom), 16'($urandom));
		run_random(24);
		wait_idle();
		quiet = 1'b0;
		set_config(FONT_NONE, 16'($urandom), 16'($urandom));
		run_random(10);
		wait_idle();
		set_config(2'($urandom_range(0, 2)), 16'hFFFF, 16'h0000);
		run_random(24);
		wait_idle();

		$display("run covered %0d row renders and %0d font store writes", n_renders, n_writes);
		$display("%0d pixels checked over small, middle, big and unknown font settings",
			sb.pixels_seen);
		if (sb.errors == 0) begin
			$display("glyph_row_pixel_expander_unit: match");
		end else begin
			$display("%0d errors", sb.errors);
			$display("glyph_row_pixel_expander_unit: mismatch");
		end
		$finish;
	end

endmodule

FILE: glyph_row_pixel_expander_unit.f
hdl/grpe_pkg.sv
hdl/grpe_ram.sv
hdl/grpe_serializer.sv
hdl/glyph_row_pixel_expander_unit.sv
sim/tb_glyph_row_pixel_expander_unit.sv
